// ===== hdl/ewv_pkg.sv =====
// Package for the encoder window velocity unit: payload types and constants.
package ewv_pkg;

	localparam int WINDOW_DEPTH_DEF = 64;

	localparam int WSIZE_W   = 7;
	localparam int POS_W     = 16;
	localparam int SUM_W     = 22;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 16;

	localparam int LONG_W  = 5;
	localparam int SHORT_W = 4;

	localparam logic [LONG_W-1:0]  LONG_PERIOD  = LONG_W'(20);
	localparam logic [SHORT_W-1:0] SHORT_PERIOD = SHORT_W'(10);

	localparam int WSIZE_RESET = 10;
	localparam logic [POS_W-1:0] PPR_RESET = POS_W'(1024);

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV = CFG_IDX_W'(1);

	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_PRIME = 1'b1;

	typedef struct packed {
		logic             action;
		logic [POS_W-1:0] counter_value;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0] delta_pulses;
		logic [SUM_W-1:0] window_sum;
		logic             velocity_due;
		logic             position_due;
		logic             indicator;
		logic [POS_W-1:0] position_echo;
	} out_item_t;

endpackage

// ===== hdl/encoder_window_velocity_unit.sv =====
// Encoder window velocity unit: pulse delta, moving-window sum and update periods.
// Path: an accepted item is registered in stage 1 and then in the output register, which
//   holds the result until the result transfer.
// Throughput: one item per cycle unless the output stalls; the ring memory is read on
//   input transfer and written when stage 1 retires a tick, with a bypass on one entry.
// Reset (arst_n low, asynchronous): ring valid bits, sum, index, counters, indicator,
//   last position and config registers return to their defaults; no clearing pass.
module encoder_window_velocity_unit
	import ewv_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	// Ring address width and a compare width wide enough for both the index+1
	// and the window size register.
	localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CMP_W = ((AW + 1) > WSIZE_W) ? (AW + 1) : WSIZE_W;
	localparam int WSIZE_RST_VAL = (WSIZE_RESET < WINDOW_DEPTH) ? WSIZE_RESET : WINDOW_DEPTH;

	// ---------------------------------------------------------------------
	// Configuration: always ready; the user writes only while idle, which is not enforced.
	// ---------------------------------------------------------------------
	logic [WSIZE_W-1:0] window_size_q;
	logic [POS_W-1:0]   ppr_q;
	logic               cfg_xfer;
	logic [CMP_W-1:0]   cfg_ws_ext;
	logic [WSIZE_W-1:0] cfg_ws_clamped;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;

	// Clamp the written window size into 1..WINDOW_DEPTH.
	always_comb begin
		cfg_ws_ext = CMP_W'(cfg_data[WSIZE_W-1:0]);
		if (cfg_ws_ext == '0) begin
			cfg_ws_clamped = WSIZE_W'(1);
		end else if (cfg_ws_ext > CMP_W'(WINDOW_DEPTH)) begin
			cfg_ws_clamped = WSIZE_W'(WINDOW_DEPTH);
		end else begin
			cfg_ws_clamped = cfg_data[WSIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WSIZE_W'(WSIZE_RST_VAL);
			ppr_q         <= PPR_RESET;
		end else if (cfg_xfer) begin
			if (cfg_index == REG_WINDOW_SIZE) begin
				window_size_q <= cfg_ws_clamped;
			end else if (cfg_index == REG_PULSES_PER_REV) begin
				ppr_q <= cfg_data[POS_W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Pipeline handshake: stage 1 holds the accepted item, the output
	// register holds the finished result.
	// ---------------------------------------------------------------------
	logic s1_valid_s1;
	logic out_valid_q;
	logic s1_adv;
	logic in_xfer;

	assign s1_adv   = s1_valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~s1_valid_s1 | s1_adv;
	assign in_xfer  = in_valid & in_ready;

	// ---------------------------------------------------------------------
	// Front end: everything that does not depend on ring contents is settled
	// on the input transfer (delta, ring address, period flags, indicator).
	// ---------------------------------------------------------------------
	logic [POS_W-1:0]   last_pos_q;
	logic [AW-1:0]      ring_idx_q;
	logic [LONG_W-1:0]  long_cnt_q;
	logic [SHORT_W-1:0] short_cnt_q;
	logic               ind_q;

	logic               is_tick;
	logic [POS_W-1:0]   delta_c;
	logic               vel_c;
	logic               pos_c;
	logic [CMP_W-1:0]   idx_inc;
	logic [AW-1:0]      idx_next;

	assign is_tick = (in_data.action == ACT_TICK);

	// Counter dropped: wrap at pulses per revolution, all mod 2^16.
	assign delta_c = (in_data.counter_value < last_pos_q) ?
		(ppr_q - last_pos_q + in_data.counter_value) :
		(in_data.counter_value - last_pos_q);

	assign vel_c = (long_cnt_q >= LONG_PERIOD);
	assign pos_c = (short_cnt_q >= SHORT_PERIOD);

	assign idx_inc  = CMP_W'(ring_idx_q) + CMP_W'(1);
	assign idx_next = (idx_inc >= CMP_W'(window_size_q)) ? '0 : idx_inc[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q  <= '0;
			ring_idx_q  <= '0;
			long_cnt_q  <= '0;
			short_cnt_q <= '0;
			ind_q       <= 1'b0;
		end else begin
			if (cfg_xfer && cfg_index == REG_WINDOW_SIZE) begin
				ring_idx_q <= '0;
			end else if (in_xfer && is_tick) begin
				ring_idx_q <= idx_next;
			end
			if (in_xfer) begin
				last_pos_q <= in_data.counter_value;
				if (is_tick) begin
					long_cnt_q  <= vel_c ? LONG_W'(1) : long_cnt_q + LONG_W'(1);
					short_cnt_q <= pos_c ? SHORT_W'(1) : short_cnt_q + SHORT_W'(1);
					ind_q       <= ind_q ^ pos_c;
				end
			end
		end
	end

	// Stage 1 payload
	logic               tick_s1;
	logic [POS_W-1:0]   delta_s1;
	logic [POS_W-1:0]   pos_s1;
	logic               vel_s1;
	logic               posdue_s1;
	logic               ind_s1;
	logic [AW-1:0]      addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			tick_s1   <= is_tick;
			delta_s1  <= is_tick ? delta_c : '0;
			pos_s1    <= in_data.counter_value;
			vel_s1    <= is_tick & vel_c;
			posdue_s1 <= is_tick & pos_c;
			ind_s1    <= is_tick ? (ind_q ^ pos_c) : ind_q;
			addr_s1   <= ring_idx_q;
		end
	end

	// ---------------------------------------------------------------------
	// Delta ring: read on input transfer, written when stage 1 retires a
	// tick. Valid bits stand in for the reset clear; an unwritten entry
	// reads as zero.
	// ---------------------------------------------------------------------
	logic [POS_W-1:0]        ring_mem [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] ring_vld_q;
	logic [POS_W-1:0]        rd_s1;
	logic                    rd_vld_s1;
	logic                    byp_s1;
	logic [POS_W-1:0]        byp_dat_s1;
	logic                    wr_en;
	logic [POS_W-1:0]        old_delta;

	assign wr_en = s1_adv & tick_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[addr_s1] <= delta_s1;
		end
		if (in_xfer) begin
			rd_s1 <= ring_mem[ring_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
		end else if (wr_en) begin
			ring_vld_q[addr_s1] <= 1'b1;
		end
	end

	// Read and write on the same edge at the same entry: take the new data.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rd_vld_s1  <= ring_vld_q[ring_idx_q];
			byp_s1     <= wr_en && (addr_s1 == ring_idx_q);
			byp_dat_s1 <= delta_s1;
		end
	end

	assign old_delta = byp_s1 ? byp_dat_s1 : (rd_vld_s1 ? rd_s1 : '0);

	// ---------------------------------------------------------------------
	// Running sum and output register
	// ---------------------------------------------------------------------
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_next;
	out_item_t        out_q;

	assign sum_next = sum_q - SUM_W'(old_delta) + SUM_W'(delta_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				sum_q <= sum_next;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.delta_pulses  <= delta_s1;
			out_q.window_sum    <= tick_s1 ? sum_next : sum_q;
			out_q.velocity_due  <= vel_s1;
			out_q.position_due  <= posdue_s1;
			out_q.indicator     <= ind_s1;
			out_q.position_echo <= pos_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== tb/sv/tb_encoder_window_velocity_unit.sv =====
// Testbench for the encoder window velocity unit: predicted moving sums and update flags.
`timescale 1ns / 1ps

module tb_encoder_window_velocity_unit
	import ewv_pkg::*;
;

	// Watchdog: cycles in a row with no transfer on any channel.
	localparam int STALL_LIMIT = 2000;
	// Register index that maps to nothing; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(8'hC3);
	// Idling odds per cycle, in percent, for either side.
	localparam int IDLE_PCT = 24;

	// ------------------------------------------------------------------
	// Velocity predictor and result store. Holds its own copy of the ring,
	// the running sum, the period counters and both registers, and keeps
	// one expected result per accepted item in arrival order.
	// ------------------------------------------------------------------
	class velocity_scoreboard;
		int unsigned      window_len;
		logic [POS_W-1:0] pulses_per_rev;
		logic [POS_W-1:0] last_pos;
		logic [POS_W-1:0] ring [WINDOW_DEPTH_DEF];
		logic [SUM_W-1:0] window_total;
		int unsigned      ring_pos;
		int unsigned      long_ticks;
		int unsigned      short_ticks;
		logic             ind_level;
		out_item_t        expected_results [$];
		int               mismatches;

		function new();
			window_len     = (WSIZE_RESET > WINDOW_DEPTH_DEF) ? WINDOW_DEPTH_DEF : WSIZE_RESET;
			pulses_per_rev = PPR_RESET;
			last_pos       = '0;
			foreach (ring[i]) ring[i] = '0;
			window_total   = '0;
			ring_pos       = 0;
			long_ticks     = 0;
			short_ticks    = 0;
			ind_level      = 1'b0;
			mismatches     = 0;
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			int unsigned len;
			if (idx == REG_WINDOW_SIZE) begin
				// only the low seven bits count, then clamped into 1..depth
				len = 32'(val[WSIZE_W-1:0]);
				if (len < 1) len = 1;
				if (len > WINDOW_DEPTH_DEF) len = WINDOW_DEPTH_DEF;
				window_len = len;
				ring_pos   = 0;
			end else if (idx == REG_PULSES_PER_REV) begin
				pulses_per_rev = val;
			end
		endfunction

		function void note_input(in_item_t it);
			out_item_t        res;
			logic [POS_W-1:0] d;
			res = '0;
			d   = '0;
			if (it.action == ACT_TICK) begin
				// counter dropped: wrap at the revolution count, mod 2^16
				if (it.counter_value < last_pos)
					d = pulses_per_rev - last_pos + it.counter_value;
				else
					d = it.counter_value - last_pos;
				if (ring_pos >= WINDOW_DEPTH_DEF) ring_pos = 0;
				window_total = window_total - SUM_W'(ring[ring_pos]) + SUM_W'(d);
				ring[ring_pos] = d;
				ring_pos++;
				if (ring_pos >= window_len) ring_pos = 0;
				if (long_ticks >= 32'(LONG_PERIOD)) begin
					long_ticks = 0;
					res.velocity_due = 1'b1;
				end
				if (short_ticks >= 32'(SHORT_PERIOD)) begin
					short_ticks = 0;
					res.position_due = 1'b1;
					ind_level = ~ind_level;
				end
				long_ticks++;
				short_ticks++;
			end
			last_pos          = it.counter_value;
			res.delta_pulses  = d;
			res.window_sum    = window_total;
			res.indicator     = ind_level;
			res.position_echo = it.counter_value;
			expected_results.push_back(res);
		endfunction

		function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH %s: expected %0h, got %0h", field, exp_v, act_v);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("MISMATCH result with nothing outstanding, echo %0h",
						got.position_echo);
				return;
			end
			want = expected_results.pop_front();
			if (got.delta_pulses !== want.delta_pulses)
				report("delta_pulses", 32'(want.delta_pulses), 32'(got.delta_pulses));
			if (got.window_sum !== want.window_sum)
				report("window_sum", 32'(want.window_sum), 32'(got.window_sum));
			if (got.velocity_due !== want.velocity_due)
				report("velocity_due", 32'(want.velocity_due), 32'(got.velocity_due));
			if (got.position_due !== want.position_due)
				report("position_due", 32'(want.position_due), 32'(got.position_due));
			if (got.indicator !== want.indicator)
				report("indicator", 32'(want.indicator), 32'(got.indicator));
			if (got.position_echo !== want.position_echo)
				report("position_echo", 32'(want.position_echo), 32'(got.position_echo));
		endfunction
	endclass

	// ------------------------------------------------------------------
	// Clock, DUT signals and instance
	// ------------------------------------------------------------------
	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	velocity_scoreboard sb;
	bit                 idle_en;    // cleared for the long stretch with no idling
	logic [POS_W-1:0]   enc_pos;    // position of the simulated encoder shaft
	int                 quiet_cycles;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	encoder_window_velocity_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Receiving side: random back-pressure, changed at the falling edge.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		out_ready = !(idle_en && ($urandom_range(99) < IDLE_PCT));
	end

	// Every result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	// Watchdog: ends the run if nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Driving tasks. Each is entered anywhere and drives at falling edges;
	// transfers are recognised at the rising edge.
	// ------------------------------------------------------------------
	task automatic push_item(input logic act, input logic [POS_W-1:0] cv);
		in_item_t it;
		it.action        = act;
		it.counter_value = cv;
		@(negedge clk);
		// random gaps before the item; valid stays low throughout
		while (idle_en && ($urandom_range(99) < IDLE_PCT)) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = it;
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
	endtask

	// Sender holds off until every expected result has come back.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly a shaft turning forwards in small steps with wrap at the
	// revolution count; the rest is primes and arbitrary counter readings.
	task automatic run_encoder(input int n);
		int          r;
		int unsigned nxt;
		logic [POS_W-1:0] cv;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				cv = POS_W'($urandom_range(16'hFFFF));
				enc_pos = cv;
				push_item(ACT_PRIME, cv);
			end else if (r < 16) begin
				cv = POS_W'($urandom_range(16'hFFFF));
				enc_pos = cv;
				push_item(ACT_TICK, cv);
			end else begin
				nxt = 32'(enc_pos) + ((r < 22) ? $urandom_range(4000) : $urandom_range(300));
				if (sb.pulses_per_rev != 0)
					nxt = nxt % 32'(sb.pulses_per_rev);
				enc_pos = POS_W'(nxt);
				push_item(ACT_TICK, enc_pos);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		sb           = new();
		idle_en      = 1'b1;
		enc_pos      = '0;
		quiet_cycles = 0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_ready    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes of the counter, drops across the wrap, repeats,
		// primes in between; register defaults still in force.
		push_item(ACT_PRIME, 16'h0000);
		push_item(ACT_TICK,  16'hFFFF);
		push_item(ACT_TICK,  16'h0000);
		push_item(ACT_TICK,  16'h0000);
		push_item(ACT_PRIME, 16'hFFFF);
		push_item(ACT_TICK,  16'h0001);
		push_item(ACT_TICK,  16'h03FF);
		push_item(ACT_TICK,  16'h8000);
		push_item(ACT_TICK,  16'h7FFF);
		push_item(ACT_PRIME, 16'h5555);
		push_item(ACT_TICK,  16'hAAAA);
		push_item(ACT_TICK,  16'hFFFE);
		push_item(ACT_TICK,  16'h0000);
		run_encoder(80);

		// Single-entry window, widest revolution count.
		drain();
		write_reg(REG_WINDOW_SIZE, 16'h0001);
		write_reg(REG_PULSES_PER_REV, 16'hFFFF);
		run_encoder(70);

		// Full window, degenerate revolution of one count, no idling at all.
		drain();
		write_reg(REG_WINDOW_SIZE, 16'd64);
		write_reg(REG_PULSES_PER_REV, 16'h0001);
		idle_en = 1'b0;
		run_encoder(80);
		idle_en = 1'b1;

		// Oversize write (high bits dropped, then clamped) and a zero count.
		drain();
		write_reg(REG_WINDOW_SIZE, 16'hFF7F);
		write_reg(REG_PULSES_PER_REV, 16'h0000);
		run_encoder(60);

		// Shrink to three: stale entries beyond the window stay in the sum.
		drain();
		write_reg(REG_WINDOW_SIZE, 16'd3);
		write_reg(REG_PULSES_PER_REV, 16'd360);
		write_reg(REG_UNMAPPED, 16'hFFFF);
		run_encoder(40);
		drain();
		run_encoder(40);

		// Zero size clamps to one.
		drain();
		write_reg(REG_WINDOW_SIZE, 16'hFF80);
		write_reg(REG_PULSES_PER_REV, PPR_RESET);
		run_encoder(60);

		drain();
		write_reg(REG_WINDOW_SIZE, 16'd37);
		write_reg(REG_PULSES_PER_REV, 16'd4096);
		run_encoder(70);

		// Let the last results out, then a short settle for the pipeline.
		drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
